// ----- hw/rtl/ils_pkg.sv -----
// Shared types and constants of the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

    // Field widths of one request and one result
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 7;
    localparam int VAL_W      = 32;
    localparam int CNT_OUT_W  = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // Read value returned for an index past the end
    localparam logic signed [VAL_W-1:0] NOT_FOUND = -32'sd1;

    typedef enum logic [FUNC_W-1:0] {
        OP_READ   = 3'd0,
        OP_INSERT = 3'd1,
        OP_HEAD   = 3'd2,
        OP_TAIL   = 3'd3,
        OP_DELETE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_request;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        t_status                 status;
        logic [CNT_OUT_W-1:0]    entry_count;
    } t_result;

endpackage

// ----- hw/rtl/ils_ram.sv -----
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ils_ram
    import ils_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [VAL_W-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    output logic signed [VAL_W-1:0] o_rd_data
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/ils_ctrl.sv -----
// Sequencer: decodes requests, sweeps entries through the memory, builds results.
`timescale 1ns / 1ps

module ils_ctrl
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request side
    input  logic                    i_req_valid,
    output logic                    o_req_ready,
    input  t_request                i_req,
    // result side
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output t_result                 o_res,
    // memory side
    output logic                    o_wr_en,
    output logic [$clog2(CAPACITY)-1:0] o_wr_addr,
    output logic signed [VAL_W-1:0] o_wr_data,
    output logic                    o_rd_en,
    output logic [$clog2(CAPACITY)-1:0] o_rd_addr,
    input  logic signed [VAL_W-1:0] i_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_ptr, n_ptr;
    logic [AW-1:0]           r_stop, n_stop;
    logic                    r_up, n_up;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic signed [VAL_W-1:0] r_res_value, n_res_value;
    t_status                 r_res_status, n_res_status;

    t_op           w_op;
    logic [XW-1:0] w_pos_x, w_cnt_x, w_last_x, w_next_x, w_ins_x;
    logic          w_is_ins, w_full;
    logic          w_rd_ok, w_ins_ok, w_ins_shift, w_del_ok, w_del_shift;
    logic          w_at_stop;
    logic [AW-1:0] w_step_ptr;

    // Decode the offered request against the current count
    assign w_op     = t_op'(i_req.func);
    assign w_pos_x  = XW'(i_req.position);
    assign w_cnt_x  = XW'(r_count);
    assign w_last_x = w_cnt_x - XW'(1);
    assign w_next_x = w_pos_x + XW'(1);
    assign w_full   = (w_cnt_x == CAP_X);
    assign w_is_ins = (w_op == OP_INSERT) || (w_op == OP_HEAD) || (w_op == OP_TAIL);

    always_comb begin
        case (w_op)
            OP_INSERT: w_ins_x = w_pos_x;
            OP_HEAD:   w_ins_x = '0;
            default:   w_ins_x = w_cnt_x;
        endcase
    end

    assign w_rd_ok     = (w_op == OP_READ) && (w_pos_x < w_cnt_x);
    assign w_ins_ok    = w_is_ins && (w_ins_x <= w_cnt_x) && !w_full;
    assign w_ins_shift = w_ins_ok && (w_ins_x != w_cnt_x);
    assign w_del_ok    = (w_op == OP_DELETE) && (w_pos_x < w_cnt_x);
    assign w_del_shift = w_del_ok && (w_pos_x != w_last_x);

    // Sweep pointer walks down for an insert, up for a delete
    assign w_at_stop  = (r_ptr == r_stop);
    assign w_step_ptr = r_up ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (w_rd_ok) begin
                        n_state = S_READ;
                    end else if (w_ins_shift || w_del_shift) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_SHIFT: begin
                if (w_at_stop) begin
                    n_state = r_up ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory accesses and register updates
    always_comb begin
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_stop       = r_stop;
        n_up         = r_up;
        n_value      = r_value;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_ptr;
        o_wr_data    = i_rd_data;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_ptr;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res_value  = '0;
                    n_res_status = ST_DONE;
                    case (w_op)
                        OP_READ: begin
                            if (w_rd_ok) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_pos_x[AW-1:0];
                            end else begin
                                n_res_value  = NOT_FOUND;
                                n_res_status = ST_RANGE;
                            end
                        end
                        OP_INSERT, OP_HEAD, OP_TAIL: begin
                            if (w_ins_x > w_cnt_x) begin
                                n_res_status = ST_RANGE;
                            end else if (w_full) begin
                                n_res_status = ST_FULL;
                            end else if (!w_ins_shift) begin
                                // append: nothing to move
                                o_wr_en   = 1'b1;
                                o_wr_addr = w_cnt_x[AW-1:0];
                                o_wr_data = i_req.item_value;
                                n_count   = r_count + CW'(1);
                            end else begin
                                // move entries up, starting from the last one
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_last_x[AW-1:0];
                                n_ptr     = w_last_x[AW-1:0];
                                n_stop    = w_ins_x[AW-1:0];
                                n_up      = 1'b1;
                                n_value   = i_req.item_value;
                            end
                        end
                        OP_DELETE: begin
                            if (!w_del_ok) begin
                                n_res_status = ST_RANGE;
                            end else if (!w_del_shift) begin
                                // last entry: just drop it
                                n_count = r_count - CW'(1);
                            end else begin
                                // move entries down, starting after the gap
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_next_x[AW-1:0];
                                n_ptr     = w_next_x[AW-1:0];
                                n_stop    = w_last_x[AW-1:0];
                                n_up      = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_value = i_rd_data;
            end
            S_SHIFT: begin
                // write back the entry read last cycle one slot over;
                // the next read is two slots away, so no overlap
                o_wr_en   = 1'b1;
                o_wr_addr = r_up ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
                o_wr_data = i_rd_data;
                if (w_at_stop) begin
                    if (!r_up) begin
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    n_ptr     = w_step_ptr;
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_step_ptr;
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_stop;
                o_wr_data = r_value;
                n_count   = r_count + CW'(1);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Sweep and result payload
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_stop       <= n_stop;
        r_up         <= n_up;
        r_value      <= n_value;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.read_value  = r_res_value;
    assign o_res.status      = r_res_status;
    assign o_res.entry_count = w_cnt_x[CNT_OUT_W-1:0];

endmodule

// ----- hw/rtl/indexed_list_store.sv -----
// Top level of the indexed list store: stream ports, sequencer, memory, output register.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+--------------
//  s       | in  | position[6:0], item_value[38:7], pad to 40 | func[2:0]
//  m       | out | read_value[31:0], status[33:32],           | -
//          |     | entry_count[40:34], pad to 48              |
//
// The memory sweep moves one entry per cycle, bound by the single read and write
// port. A read passes S_READ, an insert with moves S_SHIFT then S_PUT, a delete
// with moves S_SHIFT; every request then waits in S_DONE until its result is taken.
// One item is in work at a time; s_tready is high while the sequencer idles.
// The output register lets the next item be taken while a result waits on m.
// Reset (synchronous, active low) empties the store; memory is not cleared.
`timescale 1ns / 1ps

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // position, item_value
    input  logic [FUNC_W-1:0]     i_s_tuser,  // func
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata   // read_value, status, entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [CNT_OUT_W-1:0] CAP_OUT = CNT_OUT_W'(CAPACITY);

    t_request                w_req;
    t_result                 w_res;
    logic                    w_res_valid, w_res_ready;
    logic                    w_wr_en, w_rd_en;
    logic [AW-1:0]           w_wr_addr, w_rd_addr;
    logic signed [VAL_W-1:0] w_wr_data, w_rd_data;
    logic                    w_s_accept;
    logic                    r_out_valid;
    t_result                 r_out;

    // Unpack the request
    assign w_req.func       = i_s_tuser;
    assign w_req.position   = i_s_tdata[POS_W-1:0];
    assign w_req.item_value = i_s_tdata[POS_W+VAL_W-1:POS_W];
    assign w_s_accept       = i_s_tvalid && o_s_tready;

    ils_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    ils_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: take a result when empty or being drained
    assign w_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - VAL_W - 2 - CNT_OUT_W)'(0), r_out.entry_count,
                         r_out.status, r_out.read_value};

    // An accepted item always keeps the sequencer busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> !o_s_tready)
        else $error("sequencer idle right after accepting an item");

    // Handing a result to the output register frees the sequencer
    a_handoff_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> o_s_tready)
        else $error("sequencer not idle after result handoff");

    // A full status only happens with the store full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && (w_res.status == ST_FULL)) |-> (w_res.entry_count == CAP_OUT))
        else $error("full status with store not full");

endmodule

// ----- tb/tb_indexed_list_store.sv -----
// Self-checking testbench for the indexed list store: directed table, then a random request mix.
`timescale 1ns / 1ps

module tb_indexed_list_store;
    import ils_pkg::*;

    localparam int LIST_DEPTH    = 64;
    localparam int RANDOM_ITEMS  = 1125;
    localparam int STEADY_FIRST  = 400;
    localparam int STEADY_LAST   = 600;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 80;
    localparam int ROWS          = 25;

    // Function codes the block does not define
    localparam logic [FUNC_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] OP_SPARE_HI  = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_NOISE} t_mix;

    typedef struct {
        logic [FUNC_W-1:0]       func;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
        bit                      typed;
        t_result                 want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // position, item_value
    logic [FUNC_W-1:0]     i_s_tuser;   // func
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // read_value, status, entry_count

    // Shadow copy of the list and the replies still owed by the block
    logic signed [VAL_W-1:0] list_words [LIST_DEPTH];
    int                      list_len;
    t_result                 list_replies_due [$];

    bit steady_flow;
    int fault_count;
    int quiet_cycles;
    int n_reads, n_inserts, n_deletes, n_spare, n_range, n_full, peak_len;

    logic signed [VAL_W-1:0] got_value;
    logic [1:0]              got_status;
    logic [CNT_OUT_W-1:0]    got_count;
    t_result                 due;

    // Directed rows; typed expectations only where they are obvious
    t_row directed_rows [ROWS] = '{
        '{OP_READ,      7'd0,   32'sd0,         1'b1, '{NOT_FOUND, ST_RANGE, 7'd0}},
        '{OP_DELETE,    7'd0,   32'sd0,         1'b1, '{32'sd0,    ST_RANGE, 7'd0}},
        '{OP_INSERT,    7'd1,   32'sd9,         1'b1, '{32'sd0,    ST_RANGE, 7'd0}},
        '{OP_SPARE_LO,  7'd0,   32'sd5,         1'b1, '{32'sd0,    ST_DONE,  7'd0}},
        '{OP_SPARE_HI,  7'd127, VAL_MIN,        1'b1, '{32'sd0,    ST_DONE,  7'd0}},
        '{OP_INSERT,    7'd0,   VAL_MAX,        1'b1, '{32'sd0,    ST_DONE,  7'd1}},
        '{OP_HEAD,      7'd127, VAL_MIN,        1'b1, '{32'sd0,    ST_DONE,  7'd2}},
        '{OP_TAIL,      7'd127, -32'sd1,        1'b1, '{32'sd0,    ST_DONE,  7'd3}},
        '{OP_INSERT,    7'd3,   32'sd0,         1'b1, '{32'sd0,    ST_DONE,  7'd4}},
        '{OP_READ,      7'd0,   32'sd0,         1'b1, '{VAL_MIN,   ST_DONE,  7'd4}},
        '{OP_READ,      7'd1,   32'sd0,         1'b1, '{VAL_MAX,   ST_DONE,  7'd4}},
        '{OP_READ,      7'd2,   32'sd0,         1'b1, '{-32'sd1,   ST_DONE,  7'd4}},
        '{OP_READ,      7'd3,   32'sd0,         1'b1, '{32'sd0,    ST_DONE,  7'd4}},
        '{OP_READ,      7'd4,   32'sd0,         1'b1, '{NOT_FOUND, ST_RANGE, 7'd4}},
        '{OP_READ,      7'd127, 32'sd0,         1'b1, '{NOT_FOUND, ST_RANGE, 7'd4}},
        '{OP_INSERT,    7'd2,   32'sh5A5A_A5A5, 1'b0, '{32'sd0,    ST_DONE,  7'd0}},
        '{OP_READ,      7'd2,   32'sd0,         1'b0, '{32'sd0,    ST_DONE,  7'd0}},
        '{OP_DELETE,    7'd127, 32'sd0,         1'b1, '{32'sd0,    ST_RANGE, 7'd5}},
        '{OP_INSERT,    7'd127, 32'sd1,         1'b1, '{32'sd0,    ST_RANGE, 7'd5}},
        '{OP_INSERT,    7'd6,   32'sd1,         1'b1, '{32'sd0,    ST_RANGE, 7'd5}},
        '{OP_DELETE,    7'd4,   32'sd0,         1'b1, '{32'sd0,    ST_DONE,  7'd4}},
        '{OP_DELETE,    7'd0,   32'sd0,         1'b1, '{32'sd0,    ST_DONE,  7'd3}},
        '{OP_READ,      7'd0,   32'sd0,         1'b0, '{32'sd0,    ST_DONE,  7'd0}},
        '{OP_SPARE_MID, 7'd64,  -32'sd1,        1'b1, '{32'sd0,    ST_DONE,  7'd3}},
        '{OP_INSERT,    7'd64,  32'sd1,         1'b1, '{32'sd0,    ST_RANGE, 7'd3}}
    };

    indexed_list_store #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Open a slot at pos and shift later words up
    function automatic t_status place_word(int pos, logic signed [VAL_W-1:0] value);
        if (pos > list_len) return ST_RANGE;
        if (list_len >= LIST_DEPTH) return ST_FULL;
        for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
        list_words[pos] = value;
        list_len++;
        return ST_DONE;
    endfunction

    // Apply one request to the shadow list and return the reply it must give
    function automatic t_result predict_list_op(logic [FUNC_W-1:0] func,
                                                logic [POS_W-1:0] position,
                                                logic signed [VAL_W-1:0] value);
        t_result reply;
        int      pos;
        pos = int'(position);
        reply.read_value = '0;
        reply.status     = ST_DONE;
        case (func)
            OP_READ: begin
                n_reads++;
                if (pos < list_len) begin
                    reply.read_value = list_words[pos];
                end else begin
                    reply.read_value = NOT_FOUND;
                    reply.status     = ST_RANGE;
                end
            end
            OP_INSERT: begin
                n_inserts++;
                reply.status = place_word(pos, value);
            end
            OP_HEAD: begin
                n_inserts++;
                reply.status = place_word(0, value);
            end
            OP_TAIL: begin
                n_inserts++;
                reply.status = place_word(list_len, value);
            end
            OP_DELETE: begin
                n_deletes++;
                if (pos < list_len) begin
                    for (int i = pos; i < list_len - 1; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end else begin
                    reply.status = ST_RANGE;
                end
            end
            default: n_spare++;
        endcase
        if (reply.status == ST_RANGE) n_range++;
        if (reply.status == ST_FULL) n_full++;
        if (list_len > peak_len) peak_len = list_len;
        reply.entry_count = list_len[CNT_OUT_W-1:0];
        return reply;
    endfunction

    // Offer one item, after a random gap unless the flow is steady; log its reply once it is taken
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] position,
                                input logic signed [VAL_W-1:0] value, input bit typed,
                                input t_result want);
        t_result predicted;
        while (!steady_flow && $urandom_range(0, 99) < 37) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, value, position};
        i_s_tuser  <= func;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_list_op(func, position, value);
        list_replies_due.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Hold the sender until the block has answered everything
    task automatic wait_for_replies();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (list_replies_due.size() != 0);
    endtask

    // Receiver backpressure
    always @(negedge i_clk) begin
        i_m_tready <= steady_flow || ($urandom_range(0, 99) >= 37);
    end

    // Compare each reply with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_value  = o_m_tdata[VAL_W-1:0];
            got_status = o_m_tdata[VAL_W+1:VAL_W];
            got_count  = o_m_tdata[VAL_W+2+CNT_OUT_W-1:VAL_W+2];
            if (list_replies_due.size() == 0) begin
                $display("%0t: unexpected reply: value %0d status %0d count %0d",
                         $time, got_value, got_status, got_count);
                fault_count++;
            end else begin
                due = list_replies_due.pop_front();
                if (got_value !== due.read_value) begin
                    $display("%0t: read_value expected %0d, got %0d",
                             $time, due.read_value, got_value);
                    fault_count++;
                end
                if (got_status !== due.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, due.status, got_status);
                    fault_count++;
                end
                if (got_count !== due.entry_count) begin
                    $display("%0t: entry_count expected %0d, got %0d",
                             $time, due.entry_count, got_count);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int                      sent;
        int                      phase_len;
        int                      roll;
        int                      span;
        int                      ins_cut;
        int                      read_cut;
        int                      del_cut;
        t_mix                    mix;
        logic [FUNC_W-1:0]       op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        list_len     = 0;
        steady_flow  = 1'b0;
        sent         = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].func, directed_rows[r].position,
                         directed_rows[r].item_value, directed_rows[r].typed,
                         directed_rows[r].want);
        end
        wait_for_replies();

        // Random phases that grow, shrink or churn the list
        while (sent < RANDOM_ITEMS) begin
            mix       = t_mix'($urandom_range(0, 3));
            phase_len = $urandom_range(40, 160);
            case (mix)
                MIX_GROW:   begin ins_cut = 70; read_cut = 85; del_cut = 97; end
                MIX_SHRINK: begin ins_cut = 15; read_cut = 40; del_cut = 97; end
                default:    begin ins_cut = 35; read_cut = 65; del_cut = 96; end
            endcase
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                steady_flow = (sent >= STEADY_FIRST && sent < STEADY_LAST);
                roll = $urandom_range(0, 99);
                if (mix == MIX_NOISE) begin
                    op = FUNC_W'($urandom_range(0, 7));
                end else if (roll < ins_cut) begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_INSERT;
                        1:       op = OP_HEAD;
                        default: op = OP_TAIL;
                    endcase
                end else if (roll < read_cut) begin
                    op = OP_READ;
                end else if (roll < del_cut) begin
                    op = OP_DELETE;
                end else begin
                    op = FUNC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                end

                // Mostly a valid index, sometimes just past the end or anywhere
                span = (op == OP_INSERT) ? list_len : list_len - 1;
                case ($urandom_range(0, 9))
                    0:       position = POS_W'($urandom_range(0, 127));
                    1:       position = POS_W'(list_len + 1);
                    default: position = (span < 0) ? '0 : POS_W'($urandom_range(0, span));
                endcase
                if (mix == MIX_NOISE) position = POS_W'($urandom_range(0, 127));

                case ($urandom_range(0, 31))
                    0:       value = VAL_MAX;
                    1:       value = VAL_MIN;
                    2:       value = -32'sd1;
                    3:       value = 32'sd0;
                    default: value = $urandom;
                endcase

                send_request(op, position, value, 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 2) == 0) wait_for_replies();
        end
        steady_flow = 1'b0;

        // Drain and let the block settle
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d reads, %0d inserts, %0d deletes and %0d undefined codes.",
                 n_reads, n_inserts, n_deletes, n_spare);
        $display("Index errors %0d, full-list refusals %0d, longest list %0d of %0d entries.",
                 n_range, n_full, peak_len, LIST_DEPTH);
        if (fault_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ils_pkg.sv
hw/rtl/ils_ram.sv
hw/rtl/ils_ctrl.sv
hw/rtl/indexed_list_store.sv
tb/tb_indexed_list_store.sv
